// ----- design/cjs_pkg.sv -----
package cjs_pkg;

   localparam int DampW = 15;
   localparam logic [DampW-1:0] DampReset = 15'd24576;
   localparam int DivSteps = 32;

   // Beat state carried through the restoring divider, both lanes share one divisor.
   typedef struct packed {
      logic        valid;
      logic        last;
      logic        zero;
      logic        ovf_re;
      logic        ovf_im;
      logic        neg_re;
      logic        neg_im;
      logic [63:0] m;
      logic [63:0] r_re;
      logic [63:0] r_im;
      logic [31:0] low_re;
      logic [31:0] low_im;
      logic [31:0] q_re;
      logic [31:0] q_im;
   } div_type;

endpackage

// ----- design/cjs_front.sv -----
module cjs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [31:0]        diag_re,
   input  logic signed [31:0]        diag_im,
   input  logic signed [31:0]        rhs_re,
   input  logic signed [31:0]        rhs_im,
   input  logic                      last_in,
   input  logic [cjs_pkg::DampW-1:0] damping,
   output cjs_pkg::div_type          out
);

   // stage 1: products
   logic               v1_ff, last1_ff;
   logic signed [63:0] pdd_re_ff, pdd_im_ff, prr_ff, pii_ff, pri_ff, pir_ff;
   // stage 2: magnitude squared and sign-magnitude numerators
   logic               v2_ff, last2_ff, zero2_ff, neg_re2_ff, neg_im2_ff;
   logic [63:0]        m2_ff, mag_re2_ff, mag_im2_ff;
   // stage 3: partial products with damping
   logic               v3_ff, last3_ff, zero3_ff, neg_re3_ff, neg_im3_ff;
   logic [63:0]        m3_ff;
   logic [48:0]        lo_re3_ff, hi_re3_ff, lo_im3_ff, hi_im3_ff;
   // stage 4: scaled numerators
   logic               v4_ff, last4_ff, zero4_ff, neg_re4_ff, neg_im4_ff;
   logic [63:0]        m4_ff;
   logic [80:0]        nk_re4_ff, nk_im4_ff;
   cjs_pkg::div_type   out_ff, out_in;

   logic signed [64:0] sum_re_in, sum_im_in;
   logic [64:0]        abs_re_in, abs_im_in;
   logic [16:0]        k_in;

   always_comb begin
      sum_re_in = {prr_ff[63], prr_ff} + {pii_ff[63], pii_ff};
      sum_im_in = {pri_ff[63], pri_ff} - {pir_ff[63], pir_ff};
      abs_re_in = sum_re_in[64] ? 65'(-sum_re_in) : 65'(sum_re_in);
      abs_im_in = sum_im_in[64] ? 65'(-sum_im_in) : 65'(sum_im_in);
      k_in      = {damping, 2'b00};
   end

   always_comb begin
      out_in        = '0;
      out_in.valid  = v4_ff;
      out_in.last   = last4_ff;
      out_in.zero   = zero4_ff;
      out_in.neg_re = neg_re4_ff;
      out_in.neg_im = neg_im4_ff;
      out_in.m      = m4_ff;
      out_in.ovf_re = {15'd0, nk_re4_ff[80:32]} >= m4_ff;
      out_in.ovf_im = {15'd0, nk_im4_ff[80:32]} >= m4_ff;
      out_in.r_re   = {15'd0, nk_re4_ff[80:32]};
      out_in.r_im   = {15'd0, nk_im4_ff[80:32]};
      out_in.low_re = nk_re4_ff[31:0];
      out_in.low_im = nk_im4_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
      end else if (en) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= out_in.valid;
      end
      if (en) begin
         last1_ff   <= last_in;
         pdd_re_ff  <= diag_re * diag_re;
         pdd_im_ff  <= diag_im * diag_im;
         prr_ff     <= diag_re * rhs_re;
         pii_ff     <= diag_im * rhs_im;
         pri_ff     <= diag_re * rhs_im;
         pir_ff     <= diag_im * rhs_re;

         last2_ff   <= last1_ff;
         m2_ff      <= 64'(pdd_re_ff) + 64'(pdd_im_ff);
         zero2_ff   <= (pdd_re_ff == 64'sd0) && (pdd_im_ff == 64'sd0);
         neg_re2_ff <= sum_re_in[64];
         neg_im2_ff <= sum_im_in[64];
         mag_re2_ff <= abs_re_in[63:0];
         mag_im2_ff <= abs_im_in[63:0];

         last3_ff   <= last2_ff;
         zero3_ff   <= zero2_ff;
         neg_re3_ff <= neg_re2_ff;
         neg_im3_ff <= neg_im2_ff;
         m3_ff      <= m2_ff;
         lo_re3_ff  <= 49'(mag_re2_ff[31:0]) * 49'(k_in);
         hi_re3_ff  <= 49'(mag_re2_ff[63:32]) * 49'(k_in);
         lo_im3_ff  <= 49'(mag_im2_ff[31:0]) * 49'(k_in);
         hi_im3_ff  <= 49'(mag_im2_ff[63:32]) * 49'(k_in);

         last4_ff   <= last3_ff;
         zero4_ff   <= zero3_ff;
         neg_re4_ff <= neg_re3_ff;
         neg_im4_ff <= neg_im3_ff;
         m4_ff      <= m3_ff;
         nk_re4_ff  <= {hi_re3_ff, 32'd0} + {32'd0, lo_re3_ff};
         nk_im4_ff  <= {hi_im3_ff, 32'd0} + {32'd0, lo_im3_ff};

         out_ff.last   <= out_in.last;
         out_ff.zero   <= out_in.zero;
         out_ff.ovf_re <= out_in.ovf_re;
         out_ff.ovf_im <= out_in.ovf_im;
         out_ff.neg_re <= out_in.neg_re;
         out_ff.neg_im <= out_in.neg_im;
         out_ff.m      <= out_in.m;
         out_ff.r_re   <= out_in.r_re;
         out_ff.r_im   <= out_in.r_im;
         out_ff.low_re <= out_in.low_re;
         out_ff.low_im <= out_in.low_im;
         out_ff.q_re   <= out_in.q_re;
         out_ff.q_im   <= out_in.q_im;
      end
   end

   assign out = out_ff;

endmodule

// ----- design/cjs_div_step.sv -----
module cjs_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  cjs_pkg::div_type in,
   output cjs_pkg::div_type out
);

   cjs_pkg::div_type out_ff, out_in;
   logic [64:0]      t_re, t_im;
   logic             b_re, b_im;

   // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      t_re   = {in.r_re, in.low_re[31]};
      t_im   = {in.r_im, in.low_im[31]};
      b_re   = t_re >= {1'b0, in.m};
      b_im   = t_im >= {1'b0, in.m};
      out_in = in;
      if (b_re) begin
         t_re = t_re - {1'b0, in.m};
      end
      if (b_im) begin
         t_im = t_im - {1'b0, in.m};
      end
      out_in.r_re   = t_re[63:0];
      out_in.r_im   = t_im[63:0];
      out_in.low_re = {in.low_re[30:0], 1'b0};
      out_in.low_im = {in.low_im[30:0], 1'b0};
      out_in.q_re   = {in.q_re[30:0], b_re};
      out_in.q_im   = {in.q_im[30:0], b_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= out_in.valid;
      end
      if (en) begin
         out_ff.last   <= out_in.last;
         out_ff.zero   <= out_in.zero;
         out_ff.ovf_re <= out_in.ovf_re;
         out_ff.ovf_im <= out_in.ovf_im;
         out_ff.neg_re <= out_in.neg_re;
         out_ff.neg_im <= out_in.neg_im;
         out_ff.m      <= out_in.m;
         out_ff.r_re   <= out_in.r_re;
         out_ff.r_im   <= out_in.r_im;
         out_ff.low_re <= out_in.low_re;
         out_ff.low_im <= out_in.low_im;
         out_ff.q_re   <= out_in.q_re;
         out_ff.q_im   <= out_in.q_im;
      end
   end

   assign out = out_ff;

endmodule

// ----- design/complex_damped_jacobi_scale.sv -----
// Pipeline: 5 front stages, 32 restoring divider steps and 1 saturation/output stage.
// Throughput: one beat per cycle; the whole pipeline holds when the rsp beat stalls.
// Reset: synchronous, active high; clears all valid bits and loads damping with 1.5.
module complex_damped_jacobi_scale #(
   parameter logic [cjs_pkg::DampW-1:0] DAMP_RESET = cjs_pkg::DampReset
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [cjs_pkg::DampW-1:0] csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_diag_re,
   input  logic signed [31:0]        req_diag_im,
   input  logic signed [31:0]        req_rhs_re,
   input  logic signed [31:0]        req_rhs_im,
   input  logic                      req_last_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_sol_re,
   output logic signed [31:0]        rsp_sol_im,
   output logic                      rsp_zero_diag,
   output logic                      rsp_saturated,
   output logic                      rsp_last_out
);

   logic [cjs_pkg::DampW-1:0] damping_ff;
   logic                      en;
   cjs_pkg::div_type          stg [0:cjs_pkg::DivSteps];

   logic        valid_ff, last_ff, zero_ff, sat_ff;
   logic [31:0] sol_re_ff, sol_im_ff, sol_re_in, sol_im_in;
   logic        sat_re_in, sat_im_in;

   // Damping register; the user must write it only while the pipeline is empty; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff <= DAMP_RESET;
      end else if (csr_wr_en) begin
         damping_ff <= csr_wr_data;
      end
   end

   // Advance every stage unless a finished beat waits at the output and rsp_ready is low.
   assign en        = !valid_ff || rsp_ready;
   assign req_ready = en;

   cjs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .diag_re  (req_diag_re),
      .diag_im  (req_diag_im),
      .rhs_re   (req_rhs_re),
      .rhs_im   (req_rhs_im),
      .last_in  (req_last_in),
      .damping  (damping_ff),
      .out      (stg[0])
   );

   // Quotient bits come out MSB first, one per stage.
   for (genvar i = 0; i < cjs_pkg::DivSteps; i++) begin : g_div
      cjs_div_step u_step (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .in    (stg[i]),
         .out   (stg[i+1])
      );
   end

   // Apply sign and clip each lane; an overflowed quotient always clips unless the diagonal is zero.
   always_comb begin
      sat_re_in = 1'b0;
      sat_im_in = 1'b0;
      if (stg[cjs_pkg::DivSteps].neg_re) begin
         if (stg[cjs_pkg::DivSteps].ovf_re || stg[cjs_pkg::DivSteps].q_re > 32'h8000_0000) begin
            sat_re_in = 1'b1;
            sol_re_in = 32'h8000_0000;
         end else begin
            sol_re_in = 32'd0 - stg[cjs_pkg::DivSteps].q_re;
         end
      end else begin
         if (stg[cjs_pkg::DivSteps].ovf_re || stg[cjs_pkg::DivSteps].q_re > 32'h7FFF_FFFF) begin
            sat_re_in = 1'b1;
            sol_re_in = 32'h7FFF_FFFF;
         end else begin
            sol_re_in = stg[cjs_pkg::DivSteps].q_re;
         end
      end
      if (stg[cjs_pkg::DivSteps].neg_im) begin
         if (stg[cjs_pkg::DivSteps].ovf_im || stg[cjs_pkg::DivSteps].q_im > 32'h8000_0000) begin
            sat_im_in = 1'b1;
            sol_im_in = 32'h8000_0000;
         end else begin
            sol_im_in = 32'd0 - stg[cjs_pkg::DivSteps].q_im;
         end
      end else begin
         if (stg[cjs_pkg::DivSteps].ovf_im || stg[cjs_pkg::DivSteps].q_im > 32'h7FFF_FFFF) begin
            sat_im_in = 1'b1;
            sol_im_in = 32'h7FFF_FFFF;
         end else begin
            sol_im_in = stg[cjs_pkg::DivSteps].q_im;
         end
      end
      // Zero diagonal: drop the divider output and flag it.
      if (stg[cjs_pkg::DivSteps].zero) begin
         sat_re_in = 1'b0;
         sat_im_in = 1'b0;
         sol_re_in = 32'd0;
         sol_im_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= stg[cjs_pkg::DivSteps].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sol_re_ff <= sol_re_in;
         sol_im_ff <= sol_im_in;
         zero_ff   <= stg[cjs_pkg::DivSteps].zero;
         sat_ff    <= sat_re_in || sat_im_in;
         last_ff   <= stg[cjs_pkg::DivSteps].last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_sol_re    = sol_re_ff;
   assign rsp_sol_im    = sol_im_ff;
   assign rsp_zero_diag = zero_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_last_out  = last_ff;

endmodule

// ----- tb/sv/tb_complex_damped_jacobi_scale.sv -----
module tb_complex_damped_jacobi_scale;
   timeunit 1ns;
   timeprecision 1ps;

   // One element going in, and the solution expected for it.
   typedef struct {
      logic signed [31:0] diag_re;
      logic signed [31:0] diag_im;
      logic signed [31:0] rhs_re;
      logic signed [31:0] rhs_im;
      logic               last;
   } elem_type;

   typedef struct {
      logic signed [31:0] sol_re;
      logic signed [31:0] sol_im;
      logic               zero_diag;
      logic               saturated;
      logic               last;
   } sol_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [cjs_pkg::DampW-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_diag_re = '0, req_diag_im = '0, req_rhs_re = '0, req_rhs_im = '0;
   logic req_last_in = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_sol_re, rsp_sol_im;
   logic rsp_zero_diag, rsp_saturated, rsp_last_out;

   complex_damped_jacobi_scale dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_diag_re(req_diag_re), .req_diag_im(req_diag_im),
      .req_rhs_re(req_rhs_re), .req_rhs_im(req_rhs_im), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sol_re(rsp_sol_re), .rsp_sol_im(rsp_sol_im),
      .rsp_zero_diag(rsp_zero_diag), .rsp_saturated(rsp_saturated),
      .rsp_last_out(rsp_last_out)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Shadow of the damping register, tracked as the stimulus writes it.
   logic [cjs_pkg::DampW-1:0] omega = cjs_pkg::DampReset;

   elem_type pending_elems[$];
   sol_type  expected_sols[$];
   int    mismatches = 0;
   bit    calm = 1'b0;     // no idling on either side in the last part
   bit    hold_req = 1'b0; // hold the sender off until the pipe drains
   bit    req_taken = 1'b0; // req beat accepted at the last rising edge
   int    req_gap = 0, rsp_gap = 0;

   // One signed part of omega * conj(d) * r / |d|^2, truncated toward zero
   // and clipped to Q16.16.  Wide enough that nothing overflows before the clip.
   function automatic logic signed [31:0] clip_part(logic signed [127:0] num,
         logic [127:0] mag2, ref logic sat);
      logic [127:0] absn, q;
      logic         neg;
      begin
         neg  = num < 0;
         absn = neg ? -num : num;
         q    = (absn * (omega * 4)) / mag2;
         if (!neg && q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
         end
         if (neg && q > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'sh8000_0000;
         end
         return neg ? -q[31:0] : q[31:0];
      end
   endfunction

   function automatic sol_type jacobi_solve(elem_type e);
      sol_type s;
      logic signed [127:0] dr, di, rr, ri, nre, nim;
      logic [127:0] mag2;
      logic sat;
      begin
         dr = e.diag_re; di = e.diag_im; rr = e.rhs_re; ri = e.rhs_im;
         mag2 = dr * dr + di * di;
         s.last = e.last;
         s.zero_diag = 1'b0;
         sat = 1'b0;
         if (mag2 == 0) begin
            s.sol_re = '0; s.sol_im = '0; s.zero_diag = 1'b1; s.saturated = 1'b0;
            return s;
         end
         nre = dr * rr + di * ri;
         nim = dr * ri - di * rr;
         s.sol_re = clip_part(nre, mag2, sat);
         s.sol_im = clip_part(nim, mag2, sat);
         s.saturated = sat;
         return s;
      end
   endfunction

   // Record the handshake at the rising edge where it happens.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
   end

   // Driver: present the oldest pending element, advance on acceptance.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the beat until accepted
      end else begin
         if (req_valid) begin
            expected_sols.push_back(jacobi_solve(pending_elems.pop_front()));
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_elems.size() > 0 && !hold_req) begin
            req_valid   <= 1'b1;
            req_diag_re <= pending_elems[0].diag_re;
            req_diag_im <= pending_elems[0].diag_im;
            req_rhs_re  <= pending_elems[0].rhs_re;
            req_rhs_im  <= pending_elems[0].rhs_im;
            req_last_in <= pending_elems[0].last;
            if (!calm && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 14);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stalls.
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 9) == 0) rsp_gap = $urandom_range(1, 14);
      end
   end

   // Monitor: compare each accepted beat with the oldest expectation.
   always @(posedge clock) begin
      sol_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sols.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp beat re=%h im=%h", rsp_sol_re,
               rsp_sol_im);
         end else begin
            want = expected_sols.pop_front();
            if (rsp_sol_re !== want.sol_re || rsp_sol_im !== want.sol_im ||
                rsp_zero_diag !== want.zero_diag || rsp_saturated !== want.saturated ||
                rsp_last_out !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp re=%h im=%h z=%b s=%b l=%b",
                            " got re=%h im=%h z=%b s=%b l=%b"},
                     want.sol_re, want.sol_im, want.zero_diag, want.saturated, want.last,
                     rsp_sol_re, rsp_sol_im, rsp_zero_diag, rsp_saturated, rsp_last_out);
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000; // small, from -2.0 up to just under 2.0
         3: return 32'sh0;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_elem(logic signed [31:0] dr, di, rr, ri, logic l);
      elem_type e;
      begin
         e.diag_re = dr; e.diag_im = di; e.rhs_re = rr; e.rhs_im = ri; e.last = l;
         pending_elems.push_back(e);
      end
   endtask

   // Let the pipe drain and the last beat retire before touching the register.
   task automatic drain();
      begin
         wait (pending_elems.size() == 0 && !req_valid && expected_sols.size() == 0);
         repeat (45) @(posedge clock);
      end
   endtask

   task automatic write_damping(logic [cjs_pkg::DampW-1:0] v);
      begin
         @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= v;
         @(negedge clock);
         csr_wr_en <= 1'b0;
         omega = v;
      end
   endtask

   task automatic random_batch(int n, bit real_only);
      begin
         repeat (n) begin
            if (real_only)
               push_elem(rand_word(), 0, rand_word(), 0, 1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 15) == 0)
               push_elem(0, 0, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
            else
               push_elem(rand_word(), rand_word(), rand_word(), rand_word(),
                  1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero diagonal, identity, real case, extremes, saturation.
      push_elem(0, 0, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
      push_elem(0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
      push_elem(32'sh0001_0000, 0, 32'sh0001_0000, 0, 1'b0);
      push_elem(32'sh0002_0000, 0, -32'sh0003_0000, 0, 1'b1);
      push_elem(0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 1'b0);
      push_elem(32'sh0000_0001, 0, 32'sh7FFF_FFFF, 0, 1'b0);
      push_elem(32'sh0000_0001, 0, 32'sh8000_0000, 0, 1'b0);
      push_elem(32'sh0000_0001, 32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
      push_elem(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
      push_elem(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
      push_elem(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 1'b0);
      push_elem(32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1, 1'b0);
      push_elem(-32'sh0001_0000, 0, 32'sh0001_0000, 0, 1'b1);
      push_elem(32'sh0003_0000, 32'sh0004_0000, 32'sh0005_0000, 0, 1'b0);
      random_batch(150, 1'b0);

      // Pause the sender until every result is back, then carry on.
      wait (pending_elems.size() == 0 && !req_valid);
      hold_req = 1'b1;
      wait (expected_sols.size() == 0);
      hold_req = 1'b0;
      random_batch(100, 1'b1);
      drain();

      // Zero damping, then the maximum, then one, then a random value, then back to the reset value.
      write_damping('0);
      push_elem(0, 0, 5, 5, 1'b1);
      random_batch(100, 1'b0);
      drain();
      write_damping('1);
      random_batch(150, 1'b0);
      drain();
      write_damping(15'd16384);
      random_batch(150, 1'b0);
      drain();
      write_damping(15'($urandom_range(1, 32766)));
      random_batch(60, 1'b0);
      drain();
      write_damping(cjs_pkg::DampReset);
      calm = 1'b1;
      random_batch(80, 1'b0);

      wait (pending_elems.size() == 0 && !req_valid);
      wait (expected_sols.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
